@@ hdl/drs_pkg.sv @@
`default_nettype none
package drs_pkg;
  localparam int          DRS_VALUE_BITS  = 32;
  localparam int          DRS_RADIX       = 10;
  // x / 10 == (x * DRS_RECIP) >> DRS_RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] DRS_RECIP       = 32'hCCCC_CCCD;
  localparam int          DRS_RECIP_SHIFT = 35;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_COUNT,
    ST_PREFIX,
    ST_SCATTER,
    ST_COPY,
    ST_EMIT
  } drs_state_t;

  typedef enum logic [1:0] {
    PH_ADDR,
    PH_MUL,
    PH_ACT
  } drs_phase_t;
endpackage
`default_nettype wire

@@ hdl/drs_ram.sv @@
`default_nettype none
module drs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

@@ hdl/decimal_radix_sorter_top.sv @@
`default_nettype none
// LSD radix sorter in base ten. Values stream in one transaction per cycle into
// a store of MAX_ITEMS entries; values past capacity are dropped. The
// transaction with tlast set starts the sort, and in_tready stays low from
// then until the final sorted value has been taken. Each store entry carries
// the value and its remaining quotient, so a digit is the quotient modulo ten
// and the next quotient comes from a reciprocal multiply. One pass runs per
// decimal digit of the largest value: a count walk over the store, a prefix
// walk over the ten buckets, a scatter walk into the buffer, and a copy-back
// walk. A largest value of zero skips all passes. Sorted values are then read
// out in order and registered before they are offered, a new read starting only
// once the previous value is taken; the final one carries tlast.
module decimal_radix_sorter_top
  import drs_pkg::*;
#(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // value
  input  wire logic        in_tlast,   // is_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // sorted_value
  output logic             out_tlast   // end_of_run
);
  localparam int VW    = DRS_VALUE_BITS;
  localparam int RADIX = DRS_RADIX;
  localparam int EW    = 2 * VW;
  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int CW    = $clog2(MAX_ITEMS + 1);
  localparam int DW    = $clog2(RADIX);

  drs_state_t    state_r, state_nxt;
  drs_phase_t    ph_r, ph_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [VW-1:0] max_r, max_nxt;
  logic [CW-1:0] bucket_r [RADIX];
  logic [CW-1:0] bucket_nxt [RADIX];
  logic [CW-1:0] start_r, start_nxt;
  logic [DW-1:0] bidx_r, bidx_nxt;
  logic [VW-1:0] q10_r, q10_nxt;
  logic [DW-1:0] qlo_r, qlo_nxt;
  logic [VW-1:0] ent_v_r, ent_v_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          ov_r, ov_nxt;
  logic          ol_r, ol_nxt;
  logic [VW-1:0] od_r, od_nxt;

  logic [VW-1:0] value_in;
  logic          full;
  logic [VW-1:0] mul_in;
  logic [EW-1:0] prod;
  logic [DW-1:0] tens_lo;
  logic [DW-1:0] digit;

  // RAMs: each entry is {quotient, value}
  logic          a_we, b_we;
  logic [AW-1:0] a_wa, a_ra, b_wa, b_ra;
  logic [EW-1:0] a_wd, a_rd, b_wd, b_rd;

  drs_ram #(.WIDTH(EW), .DEPTH(MAX_ITEMS)) u_store (
    .clk(clk), .wr_en(a_we), .wr_addr(a_wa), .wr_data(a_wd),
    .rd_addr(a_ra), .rd_data(a_rd));
  drs_ram #(.WIDTH(EW), .DEPTH(MAX_ITEMS)) u_buf (
    .clk(clk), .wr_en(b_we), .wr_addr(b_wa), .wr_data(b_wd),
    .rd_addr(b_ra), .rd_data(b_rd));

  assign value_in   = in_tdata;
  assign full       = (count_r == CW'(MAX_ITEMS));
  assign in_tready  = (state_r == ST_LOAD);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

  // divide by ten: quotient of the entry just read, or the largest value
  assign mul_in  = (state_r == ST_PREFIX) ? max_r : a_rd[EW-1:VW];
  assign prod    = EW'(mul_in) * EW'(DRS_RECIP);
  // digit = q - 10*(q/10), only the low bits matter
  assign tens_lo = {q10_r[0], 3'b000} + {q10_r[2:0], 1'b0};
  assign digit   = qlo_r - tens_lo;

  always_comb begin
    state_nxt   = state_r;
    ph_nxt      = ph_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    max_nxt     = max_r;
    bucket_nxt  = bucket_r;
    start_nxt   = start_r;
    bidx_nxt    = bidx_r;
    q10_nxt     = q10_r;
    qlo_nxt     = qlo_r;
    ent_v_nxt   = ent_v_r;
    rd_pend_nxt = 1'b0;
    ov_nxt      = ov_r;
    od_nxt      = od_r;
    ol_nxt      = ol_r;
    a_we = 1'b0; a_wa = AW'(count_r); a_wd = {value_in, value_in}; a_ra = AW'(idx_r);
    b_we = 1'b0; b_wa = AW'(bucket_r[digit]); b_wd = {q10_r, ent_v_r}; b_ra = AW'(idx_r);
    unique case (state_r)
      ST_LOAD: begin
        if (in_tvalid) begin
          if (!full) begin
            a_we = 1'b1;
            count_nxt = count_r + CW'(1);
            if (value_in > max_r) max_nxt = value_in;
          end
          if (in_tlast) begin
            idx_nxt = '0;
            ph_nxt = PH_ADDR;
            state_nxt = (max_nxt == '0) ? ST_EMIT : ST_COUNT;
          end
        end
      end
      ST_COUNT, ST_SCATTER: begin
        unique case (ph_r)
          PH_ADDR: ph_nxt = PH_MUL;
          PH_MUL: begin
            q10_nxt   = VW'(prod >> DRS_RECIP_SHIFT);
            qlo_nxt   = a_rd[VW +: DW];
            ent_v_nxt = a_rd[VW-1:0];
            ph_nxt    = PH_ACT;
          end
          PH_ACT: begin
            ph_nxt = PH_ADDR;
            bucket_nxt[digit] = bucket_r[digit] + CW'(1);
            if (state_r == ST_SCATTER) b_we = 1'b1;
            idx_nxt = idx_r + CW'(1);
            if (idx_r + CW'(1) == count_r) begin
              idx_nxt = '0;
              if (state_r == ST_COUNT) begin
                state_nxt = ST_PREFIX;
                bidx_nxt = '0;
                start_nxt = '0;
              end else begin
                state_nxt = ST_COPY;
              end
            end
          end
          default: ph_nxt = PH_ADDR;
        endcase
      end
      ST_PREFIX: begin
        bucket_nxt[bidx_r] = start_r;
        start_nxt = start_r + bucket_r[bidx_r];
        bidx_nxt = bidx_r + DW'(1);
        // advance the largest value by one digit for the pass loop
        if (bidx_r == '0) max_nxt = VW'(prod >> DRS_RECIP_SHIFT);
        if (bidx_r == DW'(RADIX - 1)) begin
          state_nxt = ST_SCATTER;
          ph_nxt = PH_ADDR;
        end
      end
      ST_COPY: begin
        if (ph_r == PH_ADDR) begin
          ph_nxt = PH_MUL;
        end else begin
          ph_nxt = PH_ADDR;
          a_we = 1'b1; a_wa = AW'(idx_r); a_wd = b_rd;
          idx_nxt = idx_r + CW'(1);
          if (idx_r + CW'(1) == count_r) begin
            idx_nxt = '0;
            for (int i = 0; i < RADIX; i++) bucket_nxt[i] = '0;
            state_nxt = (max_r == '0) ? ST_EMIT : ST_COUNT;
          end
        end
      end
      ST_EMIT: begin
        if (ov_r && out_tready) ov_nxt = 1'b0;
        if (rd_pend_r) begin
          ov_nxt = 1'b1;
          od_nxt = a_rd[VW-1:0];
          ol_nxt = (idx_r == count_r);
        end else if ((!ov_r || out_tready) && idx_r != count_r) begin
          rd_pend_nxt = 1'b1;
          idx_nxt = idx_r + CW'(1);
        end
        if (ov_r && out_tready && ol_r) begin
          state_nxt = ST_LOAD;
          count_nxt = '0;
          max_nxt = '0;
          idx_nxt = '0;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      ph_r <= PH_ADDR;
      count_r <= '0;
      idx_r <= '0;
      max_r <= '0;
      for (int i = 0; i < RADIX; i++) bucket_r[i] <= '0;
      start_r <= '0;
      bidx_r <= '0;
      q10_r <= '0;
      qlo_r <= '0;
      ent_v_r <= '0;
      rd_pend_r <= 1'b0;
      ov_r <= 1'b0;
      od_r <= '0;
      ol_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r <= ph_nxt;
      count_r <= count_nxt;
      idx_r <= idx_nxt;
      max_r <= max_nxt;
      bucket_r <= bucket_nxt;
      start_r <= start_nxt;
      bidx_r <= bidx_nxt;
      q10_r <= q10_nxt;
      qlo_r <= qlo_nxt;
      ent_v_r <= ent_v_nxt;
      rd_pend_r <= rd_pend_nxt;
      ov_r <= ov_nxt;
      od_r <= od_nxt;
      ol_r <= ol_nxt;
    end
  end

  property p_count_bound;
    @(posedge clk) disable iff (!rst_n) count_r <= CW'(MAX_ITEMS);
  endproperty
  assert property (p_count_bound) else $error("item count over capacity");

  property p_idx_bound;
    @(posedge clk) disable iff (!rst_n) idx_r <= count_r;
  endproperty
  assert property (p_idx_bound) else $error("walk index past item count");

  property p_out_hold;
    @(posedge clk) disable iff (!rst_n)
      (out_tvalid && !out_tready) |=>
        (out_tvalid && $stable(out_tdata) && $stable(out_tlast));
  endproperty
  assert property (p_out_hold) else $error("output changed under stall");

  property p_out_only_emit;
    @(posedge clk) disable iff (!rst_n) out_tvalid |-> (state_r == ST_EMIT);
  endproperty
  assert property (p_out_only_emit) else $error("output outside emit");
endmodule
`default_nettype wire

@@ verif/decimal_radix_sorter_checker.sv @@
`default_nettype none
module decimal_radix_sorter_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,
  input  wire logic        in_tlast,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,
  input  wire logic        out_tlast,
  output int               fail_count,
  output int               pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 64;
  localparam int BASE     = 10;

  typedef struct packed {
    logic [31:0] value;
    logic        run_end;
  } sorted_item_t;

  logic [31:0]  collected[$];
  logic [31:0]  largest;
  sorted_item_t sorted_queue[$];

  assign pending_count = sorted_queue.size();

  // Stable LSD passes in base ten until the largest value runs out of digits.
  function automatic void sort_collected();
    logic [31:0] remaining;
    logic [63:0] place;
    logic [31:0] buckets[BASE][$];
    int          d;
    remaining = largest;
    place = 1;
    while (remaining != 0) begin
      foreach (buckets[b]) buckets[b].delete();
      foreach (collected[i]) begin
        d = int'((64'(collected[i]) / place) % BASE);
        buckets[d].push_back(collected[i]);
      end
      collected.delete();
      for (int b = 0; b < BASE; b++) collected = {collected, buckets[b]};
      remaining = remaining / BASE;
      place = place * BASE;
    end
  endfunction

  initial begin
    fail_count = 0;
    largest = '0;
  end

  always @(posedge clk) begin
    sorted_item_t exp_item;
    if (rst_n && in_tvalid && in_tready) begin
      if (collected.size() < CAPACITY) begin
        collected.push_back(in_tdata);
        if (in_tdata > largest) largest = in_tdata;
      end
      if (in_tlast) begin
        sort_collected();
        foreach (collected[i])
          sorted_queue.push_back('{collected[i], i == collected.size() - 1});
        collected.delete();
        largest = '0;
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (sorted_queue.size() == 0) begin
        $error("unexpected output transaction: data %0d last %0b", out_tdata, out_tlast);
        fail_count++;
      end else begin
        exp_item = sorted_queue.pop_front();
        if (out_tdata !== exp_item.value) begin
          $error("sorted_value: expected %0d, actual %0d", exp_item.value, out_tdata);
          fail_count++;
        end
        if (out_tlast !== exp_item.run_end) begin
          $error("end_of_run: expected %0b, actual %0b", exp_item.run_end, out_tlast);
          fail_count++;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ verif/decimal_radix_sorter_top_tb.sv @@
`default_nettype none
module decimal_radix_sorter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  int          fail_count;
  int          pending_count;
  int          send_idle_pct = 13;
  int          recv_idle_pct = 72;
  bit          hold_off = 1'b0;
  int          quiet_cycles = 0;

  always #1 clk = ~clk;

  decimal_radix_sorter_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  decimal_radix_sorter_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // Receiver: random backpressure, or a long hold-off when asked.
  always @(posedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[decimal_radix_sorter_top] ERROR");
      $finish;
    end
  end

  // Offer one value; hold until accepted. The caller drops tvalid afterwards.
  task automatic send_value(input logic [31:0] value, input logic last_flag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last_flag;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(4))
      0: return $urandom_range(9);
      1: return $urandom_range(999);
      2: return 32'hFFFF_FFFF - $urandom_range(20);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_set(input int set_size);
    for (int i = 0; i < set_size; i++) send_value(random_value(), i == set_size - 1);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin
    int sent;
    int set_size;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single value, all zeros, extremes, and a full-store set with overflow.
    send_value(32'd0, 1'b1);
    send_value(32'hFFFF_FFFF, 1'b1);
    send_value(32'd0, 1'b0); send_value(32'd0, 1'b0); send_value(32'd0, 1'b1);
    send_value(32'hFFFF_FFFF, 1'b0); send_value(32'd10, 1'b0);
    send_value(32'd1, 1'b0); send_value(32'h5555_5555, 1'b0);
    send_value(32'hAAAA_AAAA, 1'b0); send_value(32'd100, 1'b1);
    send_value(32'd21, 1'b0); send_value(32'd12, 1'b0); send_value(32'd21, 1'b1);
    drain();
    for (int i = 0; i < 66; i++) send_value($urandom_range(99), i == 65);
    drain();

    // Send two sets while the receiver holds off, so the second set waits behind the first.
    hold_off = 1'b1;
    fork
      begin
        send_set(6);
        send_set(5);
      end
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    drain();

    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 72 : 0;
      recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 13 : 0;
      while (sent < 40 * (phase + 1)) begin
        set_size = ($urandom_range(9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 8);
        send_set(set_size);
        sent += set_size;
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("[decimal_radix_sorter_top] OK");
    else $display("[decimal_radix_sorter_top] ERROR");
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
hdl/drs_pkg.sv
hdl/drs_ram.sv
hdl/decimal_radix_sorter_top.sv
verif/decimal_radix_sorter_checker.sv
verif/decimal_radix_sorter_top_tb.sv
